// ----- hdl/baerr_pkg.sv -----
// Package: widths, word types, codes and sequencer states of the block averager.
package baerr_pkg;

  localparam int FRAC_W = 32;  // Q0.32 sample and result width
  localparam int LEN_W  = 21;  // block length width
  localparam int SUM_W  = 53;  // block sum width
  localparam int CNT_W  = 16;  // block count width
  localparam int TOT_W  = 48;  // running total width

  localparam logic [LEN_W-1:0] LEN_RESET  = LEN_W'(1024);
  localparam logic [CNT_W-1:0] MAX_BLOCKS = CNT_W'(65535);

  localparam logic KIND_SAMPLE = 1'b0;
  localparam logic KIND_CLEAR  = 1'b1;

  typedef struct packed {
    logic              kind;
    logic [FRAC_W-1:0] sample;
  } in_word_t;

  typedef struct packed {
    logic [CNT_W-1:0]  block_number;
    logic [FRAC_W-1:0] running_mean;
    logic [FRAC_W-1:0] running_error;
  } out_word_t;

  typedef logic [LEN_W-1:0] cfg_word_t;

  typedef enum logic [3:0] {
    ST_ACC,
    ST_DIV_M,
    ST_SQ_M,
    ST_DIV_AVG,
    ST_DIV_SQ,
    ST_MUL_AVG,
    ST_DIV_D,
    ST_SQRT,
    ST_OUT
  } baerr_state_e;

endpackage

// ----- hdl/baerr_stream_if.sv -----
// Interface: valid/ready channel carrying one word of a given type.
interface baerr_stream_if #(parameter type T = logic) ();
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/baerr_div.sv -----
// Module: bit-serial restoring divider, one quotient bit per cycle.
module baerr_div (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      start_i,
  input  logic [baerr_pkg::SUM_W-1:0]  dividend_i,
  input  logic [baerr_pkg::LEN_W-1:0]  divisor_i,
  output logic                      done_o,
  output logic [baerr_pkg::FRAC_W-1:0] quot_o
);
  import baerr_pkg::*;

  localparam int CW = $clog2(SUM_W);
  localparam logic [CW-1:0] LAST = CW'(SUM_W - 1);

  logic             busy_q, busy_d;
  logic             done_q, done_d;
  logic [CW-1:0]    cnt_q, cnt_d;
  logic [LEN_W:0]   rem_q, rem_d;
  logic [SUM_W-1:0] quo_q, quo_d;
  logic [LEN_W-1:0] dvs_q, dvs_d;
  logic [LEN_W:0]   trial;
  logic             fits;

  // trial remainder: previous remainder with the next dividend bit
  assign trial = {rem_q[LEN_W-1:0], quo_q[SUM_W-1]};
  assign fits  = trial >= {1'b0, dvs_q};

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    rem_d  = rem_q;
    quo_d  = quo_q;
    dvs_d  = dvs_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      rem_d  = '0;
      quo_d  = dividend_i;
      dvs_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = fits ? (trial - {1'b0, dvs_q}) : trial;
      quo_d = {quo_q[SUM_W-2:0], fits};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    rem_q <= rem_d;
    quo_q <= quo_d;
    dvs_q <= dvs_d;
  end

  assign done_o = done_q;
  // quotient saturates at full scale
  assign quot_o = (|quo_q[SUM_W-1:FRAC_W]) ? '1 : quo_q[FRAC_W-1:0];

endmodule

// ----- hdl/baerr_mul.sv -----
// Module: bit-serial shift-add multiplier giving the upper half of a Q0.32 product.
module baerr_mul (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  input  logic [baerr_pkg::FRAC_W-1:0] a_i,
  input  logic [baerr_pkg::FRAC_W-1:0] b_i,
  output logic                         done_o,
  output logic [baerr_pkg::FRAC_W-1:0] prod_hi_o
);
  import baerr_pkg::*;

  localparam int CW = $clog2(FRAC_W);
  localparam logic [CW-1:0] LAST = CW'(FRAC_W - 1);

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [FRAC_W-1:0] a_q, a_d;
  logic [FRAC_W-1:0] hi_q, hi_d;
  logic [FRAC_W-1:0] lo_q, lo_d;
  logic [FRAC_W:0]   psum;

  // add the multiplicand when the current multiplier bit is set
  assign psum = {1'b0, hi_q} + (lo_q[0] ? {1'b0, a_q} : '0);

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    a_d    = a_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      a_d    = a_i;
      hi_d   = '0;
      lo_d   = b_i;
    end else if (busy_q) begin
      hi_d  = psum[FRAC_W:1];
      lo_d  = {psum[0], lo_q[FRAC_W-1:1]};
      cnt_d = cnt_q + CW'(1);
      if (cnt_q == LAST) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cnt_q <= cnt_d;
    a_q   <= a_d;
    hi_q  <= hi_d;
    lo_q  <= lo_d;
  end

  assign done_o    = done_q;
  assign prod_hi_o = hi_q;

endmodule

// ----- hdl/block_average_with_error.sv -----
// Top level: blocking-method running mean and standard error in Q0.32.
//
// Channels (valid/ready, a word moves when both are high):
//   cfg_i : block length write (21 bits), always ready; write only while idle.
//   in_i  : {kind, sample}. kind sample adds to the current block, kind clear
//           zeroes all running statistics (block length is kept).
//   out_o : {block_number, running_mean, running_error}, one word per block.
// Throughput: one sample word per cycle inside a block. The word that closes
// a block starts the end-of-block sequence: a 53-step serial divider and a
// 32-step serial multiplier, shared over the block mean, its square, the two
// averages, the squared average and the variance divide, then a 32-step
// square root; the first block stops after the running mean. During the
// sequence in_i is not ready.
// Blocks past the maximum count close without a result and without a stall.
// The result sits in an output register; the block goes back to taking
// samples while it waits. If the receiver still holds the previous word when
// the next block finishes, the sequencer waits in its output state.
// Reset: block length 1024, all statistics zero, no word pending.
module block_average_with_error (
  input  logic           clk_i,
  input  logic           rst_ni,
  baerr_stream_if.sink   cfg_i,
  baerr_stream_if.sink   in_i,
  baerr_stream_if.source out_o
);
  import baerr_pkg::*;

  localparam int SQW = $clog2(FRAC_W);
  localparam logic [SQW-1:0] SQ_LAST = SQW'(FRAC_W - 1);

  // sequencer
  baerr_state_e state_q, state_d;
  logic         run_q, run_d;      // shared unit launched for this state

  // architectural state
  logic [LEN_W-1:0] block_length_q, block_length_d;
  logic [LEN_W-1:0] samples_q, samples_d;
  logic [SUM_W-1:0] sum_q, sum_d;
  logic [CNT_W-1:0] blocks_q, blocks_d;
  logic [TOT_W-1:0] mtot_q, mtot_d;
  logic [TOT_W-1:0] stot_q, stot_d;

  // end-of-block working registers
  logic [FRAC_W-1:0] m_q, m_d;       // block mean
  logic [FRAC_W-1:0] avg_q, avg_d;   // running mean
  logic [FRAC_W-1:0] sq_q, sq_d;     // mean of squares
  logic [FRAC_W-1:0] rad_q, rad_d;   // variance term, then root radicand
  logic [FRAC_W:0]   rem_q, rem_d;   // root remainder
  logic [FRAC_W-1:0] root_q, root_d;
  logic [SQW-1:0]    sqc_q, sqc_d;
  logic [FRAC_W-1:0] err_q, err_d;

  // output register
  logic      out_valid_q, out_valid_d;
  out_word_t out_word_q, out_word_d;

  // handshakes and decode
  logic             in_ready, in_fire, cfg_fire, out_fire, out_load;
  logic [LEN_W-1:0] len, samples_inc;
  logic [SUM_W-1:0] sum_add;
  logic             blk_end, blk_drop;

  // shared units
  logic              div_start, div_done, mul_start, mul_done;
  logic [SUM_W-1:0]  div_dividend;
  logic [LEN_W-1:0]  div_divisor;
  logic [FRAC_W-1:0] div_quot, mul_op, mul_hi;

  // one root digit step
  logic [FRAC_W+2:0] rt_rem;
  logic [FRAC_W+1:0] rt_trial;
  logic              rt_fits;
  logic [FRAC_W-1:0] rt_root;

  assign cfg_i.ready = 1'b1;
  assign cfg_fire    = cfg_i.valid && cfg_i.ready;
  assign in_i.ready  = in_ready;
  assign in_fire     = in_i.valid && in_ready;
  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_word_q;
  assign out_fire    = out_valid_q && out_o.ready;

  // zero length behaves as one
  assign len         = (block_length_q == '0) ? LEN_W'(1) : block_length_q;
  assign samples_inc = samples_q + LEN_W'(1);
  assign sum_add     = sum_q + SUM_W'(in_i.data.sample);
  assign blk_end     = samples_inc >= len;
  assign blk_drop    = blocks_q >= MAX_BLOCKS;

  assign rt_rem   = {rem_q, rad_q[FRAC_W-1 -: 2]};
  assign rt_trial = {root_q, 2'b01};
  assign rt_fits  = rt_rem >= {1'b0, rt_trial};
  assign rt_root  = {root_q[FRAC_W-2:0], rt_fits};

  // operand selection for the shared units
  always_comb begin
    div_dividend = sum_q;
    div_divisor  = len;
    mul_op       = m_q;
    unique case (state_q)
      ST_DIV_AVG: begin
        div_dividend = SUM_W'(mtot_q);
        div_divisor  = LEN_W'(blocks_q);
      end
      ST_DIV_SQ: begin
        div_dividend = SUM_W'(stot_q);
        div_divisor  = LEN_W'(blocks_q);
      end
      ST_DIV_D: begin
        div_dividend = SUM_W'(rad_q);
        div_divisor  = LEN_W'(blocks_q - CNT_W'(1));
      end
      ST_MUL_AVG: mul_op = avg_q;
      default: ;
    endcase
  end

  baerr_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  baerr_mul u_mul (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .start_i   (mul_start),
    .a_i       (mul_op),
    .b_i       (mul_op),
    .done_o    (mul_done),
    .prod_hi_o (mul_hi)
  );

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_ACC: begin
        if (in_fire && in_i.data.kind == KIND_SAMPLE && blk_end && !blk_drop) begin
          state_d = ST_DIV_M;
        end
      end
      ST_DIV_M:   if (div_done) state_d = ST_SQ_M;
      ST_SQ_M:    if (mul_done) state_d = ST_DIV_AVG;
      ST_DIV_AVG: begin
        if (div_done) state_d = (blocks_q == CNT_W'(1)) ? ST_OUT : ST_DIV_SQ;
      end
      ST_DIV_SQ:  if (div_done) state_d = ST_MUL_AVG;
      ST_MUL_AVG: if (mul_done) state_d = ST_DIV_D;
      ST_DIV_D:   if (div_done) state_d = ST_SQRT;
      ST_SQRT:    if (sqc_q == SQ_LAST) state_d = ST_OUT;
      ST_OUT:     if (out_load) state_d = ST_ACC;
      default:    state_d = ST_ACC;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_ready  = 1'b0;
    div_start = 1'b0;
    mul_start = 1'b0;
    out_load  = 1'b0;
    unique case (state_q) inside
      ST_ACC: in_ready = 1'b1;
      ST_DIV_M, ST_DIV_AVG, ST_DIV_SQ, ST_DIV_D: div_start = !run_q;
      ST_SQ_M, ST_MUL_AVG: mul_start = !run_q;
      ST_OUT: out_load = !out_valid_q || out_o.ready;
      default: ;
    endcase
  end

  // datapath
  always_comb begin
    run_d          = run_q;
    block_length_d = block_length_q;
    samples_d      = samples_q;
    sum_d          = sum_q;
    blocks_d       = blocks_q;
    mtot_d         = mtot_q;
    stot_d         = stot_q;
    m_d            = m_q;
    avg_d          = avg_q;
    sq_d           = sq_q;
    rad_d          = rad_q;
    rem_d          = rem_q;
    root_d         = root_q;
    sqc_d          = sqc_q;
    err_d          = err_q;
    out_valid_d    = out_valid_q;
    out_word_d     = out_word_q;

    if (cfg_fire) block_length_d = cfg_i.data;

    if (div_start || mul_start) run_d = 1'b1;
    if (div_done || mul_done)   run_d = 1'b0;

    case (state_q)
      ST_ACC: begin
        if (in_fire) begin
          if (in_i.data.kind == KIND_CLEAR) begin
            samples_d = '0;
            sum_d     = '0;
            blocks_d  = '0;
            mtot_d    = '0;
            stot_d    = '0;
          end else begin
            samples_d = samples_inc;
            sum_d     = sum_add;
            // past the block limit a finished block is just discarded
            if (blk_end && blk_drop) begin
              samples_d = '0;
              sum_d     = '0;
            end
          end
        end
      end
      ST_DIV_M: begin
        if (div_done) begin
          m_d       = div_quot;
          samples_d = '0;
          sum_d     = '0;
        end
      end
      ST_SQ_M: begin
        if (mul_done) begin
          blocks_d = blocks_q + CNT_W'(1);
          mtot_d   = mtot_q + TOT_W'(m_q);
          stot_d   = stot_q + TOT_W'(mul_hi);
        end
      end
      ST_DIV_AVG: begin
        if (div_done) begin
          avg_d = div_quot;
          err_d = '0;   // single block: no spread yet
        end
      end
      ST_DIV_SQ: if (div_done) sq_d = div_quot;
      ST_MUL_AVG: begin
        // negative variance clamps to zero
        if (mul_done) rad_d = (sq_q >= mul_hi) ? (sq_q - mul_hi) : '0;
      end
      ST_DIV_D: begin
        if (div_done) begin
          rad_d  = div_quot;
          rem_d  = '0;
          root_d = '0;
          sqc_d  = '0;
        end
      end
      ST_SQRT: begin
        // two radicand bits per step; zeros after the top word scale by 2^32
        rad_d  = {rad_q[FRAC_W-3:0], 2'b00};
        rem_d  = rt_fits ? (FRAC_W+1)'(rt_rem - {1'b0, rt_trial})
                         : rt_rem[FRAC_W:0];
        root_d = rt_root;
        sqc_d  = sqc_q + SQW'(1);
        if (sqc_q == SQ_LAST) err_d = rt_root;
      end
      default: ;
    endcase

    if (out_fire) out_valid_d = 1'b0;
    if (out_load) begin
      out_valid_d              = 1'b1;
      out_word_d.block_number  = blocks_q;
      out_word_d.running_mean  = avg_q;
      out_word_d.running_error = err_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= ST_ACC;
      run_q          <= 1'b0;
      block_length_q <= LEN_RESET;
      samples_q      <= '0;
      sum_q          <= '0;
      blocks_q       <= '0;
      mtot_q         <= '0;
      stot_q         <= '0;
      out_valid_q    <= 1'b0;
    end else begin
      state_q        <= state_d;
      run_q          <= run_d;
      block_length_q <= block_length_d;
      samples_q      <= samples_d;
      sum_q          <= sum_d;
      blocks_q       <= blocks_d;
      mtot_q         <= mtot_d;
      stot_q         <= stot_d;
      out_valid_q    <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    m_q        <= m_d;
    avg_q      <= avg_d;
    sq_q       <= sq_d;
    rad_q      <= rad_d;
    rem_q      <= rem_d;
    root_q     <= root_d;
    sqc_q      <= sqc_d;
    err_q      <= err_d;
    out_word_q <= out_word_d;
  end

endmodule

// ----- tb/baerr_stats_monitor.sv -----
// Checker: predicts each block result from the accepted words and compares the outputs.
module baerr_stats_monitor
  import baerr_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      cfg_valid_i,
  input  logic      cfg_ready_i,
  input  cfg_word_t cfg_data_i,
  input  logic      in_valid_i,
  input  logic      in_ready_i,
  input  in_word_t  in_data_i,
  input  logic      out_valid_i,
  input  logic      out_ready_i,
  input  out_word_t out_data_i,
  output int        fail_count_o,
  output int        pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  cfg_word_t        blk_len;
  logic [LEN_W-1:0] held_cnt;
  logic [SUM_W-1:0] held_sum;
  logic [CNT_W-1:0] done_blocks;
  logic [TOT_W-1:0] mean_sum;
  logic [TOT_W-1:0] square_sum;
  out_word_t        due_results[$];

  function automatic void zero_totals();
    held_cnt    = '0;
    held_sum    = '0;
    done_blocks = '0;
    mean_sum    = '0;
    square_sum  = '0;
  endfunction

  // floor(sqrt(v)), one result bit per step from the top
  function automatic logic [FRAC_W-1:0] root_q32(input logic [63:0] v);
    logic [31:0] r;
    logic [31:0] c;
    r = '0;
    for (int i = 31; i >= 0; i--) begin
      c = r | (32'd1 << i);
      if (64'(c) * 64'(c) <= v) r = c;
    end
    return r;
  endfunction

  // Folds one accepted word into the statistics; returns 1 when a result is due.
  function automatic bit fold_in_word(input in_word_t w, output out_word_t res);
    logic [63:0] len;
    logic [63:0] m;
    logic [63:0] n;
    logic [63:0] avg;
    logic [63:0] sq;
    logic [63:0] avg2;
    logic [63:0] d;
    res = '0;
    if (w.kind == KIND_CLEAR) begin
      zero_totals();
      return 1'b0;
    end
    held_sum = held_sum + SUM_W'(w.sample);
    held_cnt = held_cnt + 1'b1;
    len = (blk_len == '0) ? 64'd1 : 64'(blk_len);
    if (64'(held_cnt) < len) return 1'b0;
    m = 64'(held_sum) / len;
    // a length lowered mid-block can push the mean past full scale
    if (m > 64'hFFFF_FFFF) m = 64'hFFFF_FFFF;
    held_cnt = '0;
    held_sum = '0;
    if (done_blocks >= MAX_BLOCKS) return 1'b0;
    done_blocks = done_blocks + 1'b1;
    mean_sum    = mean_sum + TOT_W'(m);
    square_sum  = square_sum + TOT_W'((m * m) >> 32);
    n   = 64'(done_blocks);
    avg = (64'(mean_sum) / n) & 64'hFFFF_FFFF;
    res.block_number = done_blocks;
    res.running_mean = avg[31:0];
    if (n == 64'd1) begin
      res.running_error = '0;
    end else begin
      sq   = (64'(square_sum) / n) & 64'hFFFF_FFFF;
      avg2 = (avg * avg) >> 32;
      d    = (sq >= avg2) ? sq - avg2 : 64'd0;
      d    = d / (n - 64'd1);
      res.running_error = root_q32(d << 32);
    end
    return 1'b1;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    out_word_t want;
    out_word_t got;
    if (!rst_ni) begin
      blk_len = LEN_RESET;
      zero_totals();
      due_results.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && out_ready_i) begin
        if (due_results.size() == 0) begin
          fail_count_o++;
          if (fail_count_o <= 10)
            $display("%0t: unexpected word: n %0d mean %h err %h", $time,
                     out_data_i.block_number, out_data_i.running_mean,
                     out_data_i.running_error);
        end else begin
          want = due_results.pop_front();
          if (out_data_i.block_number !== want.block_number ||
              out_data_i.running_mean !== want.running_mean ||
              out_data_i.running_error !== want.running_error) begin
            fail_count_o++;
            if (fail_count_o <= 10)
              $display("%0t: mismatch: exp n %0d mean %h err %h, got n %0d mean %h err %h",
                       $time, want.block_number, want.running_mean, want.running_error,
                       out_data_i.block_number, out_data_i.running_mean,
                       out_data_i.running_error);
          end
        end
      end
      if (cfg_valid_i && cfg_ready_i) blk_len = cfg_data_i;
      if (in_valid_i && in_ready_i) begin
        if (fold_in_word(in_data_i, got)) due_results.push_back(got);
      end
    end
    pending_o = due_results.size();
  end

endmodule

// ----- tb/block_average_with_error_tb.sv -----
// Testbench top: drives samples, clears and block-length writes, then gives the verdict.
module block_average_with_error_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import baerr_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_e;

  localparam cfg_word_t LEN_HIGH = cfg_word_t'(1048576);  // top of the legal range
  localparam cfg_word_t LEN_TOP  = '1;                    // all 21 bits set
  localparam int        SETTLE   = 400;                   // covers the end-of-block sequence
  localparam int        HOLD_LEN = 2000;                  // long receiver hold-off

  logic       clk;
  logic       rst_n;
  idle_mode_e idle_mode;
  int         hold_id;     // bumped to request one long hold-off
  int         fail_count;
  int         pending;

  baerr_stream_if #(.T(cfg_word_t)) cfg_if ();
  baerr_stream_if #(.T(in_word_t))  in_if ();
  baerr_stream_if #(.T(out_word_t)) out_if ();

  block_average_with_error uut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cfg_i  (cfg_if),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  baerr_stats_monitor mon (
    .clk_i        (clk),
    .rst_ni       (rst_n),
    .cfg_valid_i  (cfg_if.valid),
    .cfg_ready_i  (cfg_if.ready),
    .cfg_data_i   (cfg_if.data),
    .in_valid_i   (in_if.valid),
    .in_ready_i   (in_if.ready),
    .in_data_i    (in_if.data),
    .out_valid_i  (out_if.valid),
    .out_ready_i  (out_if.ready),
    .out_data_i   (out_if.data),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  initial clk = 1'b0;
  always #5 clk = ~clk;

  // Hard stop in case the block hangs.
  initial begin
    #30_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Result side: random stalls per idling mode, plus the long hold-off on request.
  // The hold-off is counted here so the sender keeps offering words meanwhile.
  initial begin
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    out_if.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_seen != hold_id) begin
        hold_seen = hold_id;
        hold_left = HOLD_LEN;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_if.ready <= 1'b0;
      end else begin
        out_if.ready <= ($urandom_range(99) >= ((idle_mode == IDLE_RECV) ? 57 :
                                                (idle_mode == IDLE_BOTH) ? 36 : 0));
      end
    end
  end

  // Offer one input word; returns right after the edge that takes it.
  // valid stays high so back-to-back words need no extra cycle.
  task automatic push_word(input logic kind, input logic [FRAC_W-1:0] sample);
    in_word_t w;
    w.kind   = kind;
    w.sample = sample;
    @(negedge clk);
    while ($urandom_range(99) < ((idle_mode == IDLE_SEND) ? 57 :
                                 (idle_mode == IDLE_BOTH) ? 36 : 0)) begin
      in_if.valid <= 1'b0;
      @(negedge clk);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= w;
    do @(posedge clk); while (!in_if.ready);
  endtask

  // Random word: mostly samples, with the extremes weighted up and rare clears
  // so the block count gets a chance to grow.
  task automatic push_random();
    int pick;
    pick = $urandom_range(99);
    if (pick < 2)       push_word(KIND_CLEAR, $urandom());
    else if (pick < 12) push_word(KIND_SAMPLE, '0);
    else if (pick < 22) push_word(KIND_SAMPLE, '1);
    else                push_word(KIND_SAMPLE, $urandom());
  endtask

  // Stop sending, wait for every expected result, then let the sequencer settle.
  task automatic drain();
    @(negedge clk);
    in_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  // Block length write, only ever issued with the block idle.
  task automatic write_len(input cfg_word_t v);
    drain();
    @(negedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.data  <= v;
    do @(posedge clk); while (!cfg_if.ready);
    @(negedge clk);
    cfg_if.valid <= 1'b0;
  endtask

  initial begin
    idle_mode_e mode_list [4];
    cfg_word_t  len;
    int         pick;
    mode_list    = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH};
    rst_n        = 1'b0;
    in_if.valid  = 1'b0;
    in_if.data   = '0;
    cfg_if.valid = 1'b0;
    cfg_if.data  = '0;
    idle_mode    = IDLE_NONE;
    hold_id      = 0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Directed part.
    // Reset length 1024: a few words, no block may close yet.
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, '0);
    push_word(KIND_SAMPLE, 32'h8000_0000);
    push_word(KIND_SAMPLE, 32'h0000_0001);
    // Length above the legal range is taken as given.
    write_len(LEN_TOP);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, '1);
    // Lower the length below the count already held: the next word closes the
    // block and its mean overshoots full scale.
    write_len(2);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, '0);
    push_word(KIND_SAMPLE, '1);
    // Zero length behaves as one: every word is a block.
    write_len('0);
    push_word(KIND_SAMPLE, '0);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, 32'h0000_0001);
    push_word(KIND_SAMPLE, 32'h7FFF_FFFF);
    // Clear in the middle of a run; sample field is don't-care.
    push_word(KIND_CLEAR, '1);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_SAMPLE, '1);
    push_word(KIND_CLEAR, '0);
    // Top of the legal range, then cut short.
    write_len(LEN_HIGH);
    push_word(KIND_SAMPLE, $urandom());
    push_word(KIND_SAMPLE, $urandom());
    write_len(1);
    push_word(KIND_SAMPLE, $urandom());

    // Random part: each idling mode gets a few length settings. Long lengths
    // never close on their own; the next write lowers them mid-block.
    foreach (mode_list[i]) begin
      idle_mode = mode_list[i];
      repeat (3) begin
        pick = $urandom_range(99);
        if (pick < 5)       len = '0;
        else if (pick < 9)  len = LEN_TOP;
        else if (pick < 13) len = LEN_HIGH;
        else                len = cfg_word_t'($urandom_range(12, 1));
        write_len(len);
        repeat (50) push_random();
      end
    end

    // Back-pressure: one block per sample word while the receiver holds off, so the
    // output register fills, the sequencer waits and the input stalls.
    idle_mode = IDLE_NONE;
    write_len(1);
    hold_id = hold_id + 1;
    repeat (40) push_random();

    // Sender pauses until every result is in, then the verdict.
    drain();
    if (fail_count == 0 && pending == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
hdl/baerr_pkg.sv
hdl/baerr_stream_if.sv
hdl/baerr_div.sv
hdl/baerr_mul.sv
hdl/block_average_with_error.sv
tb/baerr_stats_monitor.sv
tb/block_average_with_error_tb.sv
